[hdl/rmae_pkg.sv]
// Package for the reliable message ack engine: command and action codes,
// table entry and queue item types, and default sizes. No dependencies.
package rmae_pkg;

  localparam int PENDING_DEPTH_DEF = 16;
  localparam int SEEN_DEPTH_DEF    = 64;
  localparam int MAX_RESULTS       = 16;
  localparam logic [15:0] TIMEOUT_RESET = 16'd2;

  typedef enum logic [1:0] {
    CMD_SEND = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_DATA = 2'd2,
    CMD_TICK = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_TRANSMIT   = 3'd0,
    ACT_RETRANSMIT = 3'd1,
    ACT_ACK        = 3'd2,
    ACT_DELIVER    = 3'd3,
    ACT_FULL       = 3'd4
  } act_t;

  typedef struct packed {
    logic [15:0] seq;
    logic [7:0]  handle;
    logic [7:0]  peer;
    logic [31:0] stamp;
  } pend_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] seq;
    logic [7:0]  handle;
    logic [7:0]  peer;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEND,
    ST_ACK_RD,
    ST_ACK_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_DAT_RD,
    ST_DAT_CMP,
    ST_DAT_NEW,
    ST_DAT_ACK,
    ST_TK_RD,
    ST_TK_CMP,
    ST_TK_FLUSH
  } state_t;

endpackage

[hdl/rmae_ram.sv]
// Generic single write, single read RAM with a registered read port.
// No dependencies.
module rmae_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                 wdata,
  input  logic                         re,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                 rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/rmae_front.sv]
// Front end: accepts input items, classifies the command and queues them.
// Depends on rmae_pkg.
module rmae_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_command,
  input  logic [15:0]        in_seq_num,
  input  logic [7:0]         in_msg_handle,
  input  logic [7:0]         in_peer_id,
  output logic               in_stall,
  output rmae_pkg::qhead_t   head,
  input  logic               pop
);
  import rmae_pkg::*;

  item_t      ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  item_t      item_in;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;

  always_comb begin
    item_in.cmd    = cmd_t'(in_command);
    item_in.seq    = in_seq_num;
    item_in.handle = in_msg_handle;
    item_in.peer   = in_peer_id;
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= item_in;
    end
  end

endmodule

[hdl/rmae_back.sv]
// Back end: sequencer that carries out queued commands over the pending and
// seen tables and drives the result register. Depends on rmae_pkg, rmae_ram.
module rmae_back #(
  parameter int PENDING_DEPTH = rmae_pkg::PENDING_DEPTH_DEF,
  parameter int SEEN_DEPTH    = rmae_pkg::SEEN_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rmae_pkg::qhead_t     head,
  output logic                 pop,
  input  logic [15:0]          timeout,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_action,
  output logic [15:0]          out_seq,
  output logic [7:0]           out_handle,
  output logic [7:0]           out_peer,
  output logic                 out_last,
  output logic [$clog2(PENDING_DEPTH+1)-1:0] pend_cnt,
  output logic [$clog2(SEEN_DEPTH+1)-1:0]    seen_cnt
);
  import rmae_pkg::*;

  localparam int PIW = PENDING_DEPTH > 1 ? $clog2(PENDING_DEPTH) : 1;
  localparam int PCW = $clog2(PENDING_DEPTH + 1);
  localparam int SIW = SEEN_DEPTH > 1 ? $clog2(SEEN_DEPTH) : 1;
  localparam int SCW = $clog2(SEEN_DEPTH + 1);
  localparam int KW  = $clog2(MAX_RESULTS + 1);

  state_t        state_r, state_nxt;
  item_t         it_r, it_nxt;
  logic [PCW-1:0] pi_r, pi_nxt;
  logic [SCW-1:0] si_r, si_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic [PCW-1:0] pcnt_r, pcnt_nxt;
  logic [SCW-1:0] scnt_r, scnt_nxt;
  logic [15:0]    nseq_r, nseq_nxt;
  logic [31:0]    now_r, now_nxt;
  logic           hold_v_r, hold_v_nxt;
  pend_t          hold_r, hold_nxt;
  logic           ov_r, ov_nxt;
  act_t           oact_r, oact_nxt;
  logic [15:0]    oseq_r, oseq_nxt;
  logic [7:0]     ohnd_r, ohnd_nxt;
  logic [7:0]     opeer_r, opeer_nxt;
  logic           olast_r, olast_nxt;

  // Pending table ports.
  logic           p_we, p_re;
  logic [PIW-1:0] p_waddr, p_raddr;
  logic [63:0]    p_wdata, p_rdata;
  pend_t          p_ent;
  // Seen table ports.
  logic           s_we, s_re;
  logic [SIW-1:0] s_waddr, s_raddr;
  logic [15:0]    s_rdata;

  logic        can_load;
  logic        p_match, s_match, due, pscan_end, sh_end;
  logic [31:0] age;
  logic [PCW-1:0] pj1;

  rmae_ram #(.W(64), .D(PENDING_DEPTH)) u_pend (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .re(p_re), .raddr(p_raddr), .rdata(p_rdata)
  );

  rmae_ram #(.W(16), .D(SEEN_DEPTH)) u_seen (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(it_r.seq),
    .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
  );

  assign p_ent     = pend_t'(p_rdata);
  assign can_load  = !ov_r || !out_stall;
  assign p_match   = (p_ent.seq == it_r.seq);
  assign s_match   = (s_rdata == it_r.seq);
  assign age       = now_r - p_ent.stamp;
  assign due       = (age >= {16'd0, timeout});
  assign pscan_end = (pi_r >= pcnt_r) || (k_r >= KW'(MAX_RESULTS));
  assign pj1       = pi_r + PCW'(1);
  assign sh_end    = (pj1 >= pcnt_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          case (head.item.cmd)
            CMD_SEND: state_nxt = ST_SEND;
            CMD_ACK:  state_nxt = ST_ACK_RD;
            CMD_DATA: state_nxt = ST_DAT_RD;
            CMD_TICK: state_nxt = ST_TK_RD;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SEND:    if (can_load) state_nxt = ST_IDLE;
      ST_ACK_RD:  state_nxt = (pi_r >= pcnt_r) ? ST_IDLE : ST_ACK_CMP;
      ST_ACK_CMP: state_nxt = p_match ? ST_SH_RD : ST_ACK_RD;
      ST_SH_RD:   state_nxt = sh_end ? ST_IDLE : ST_SH_WR;
      ST_SH_WR:   state_nxt = ST_SH_RD;
      ST_DAT_RD:  state_nxt = (si_r >= scnt_r) ? ST_DAT_NEW : ST_DAT_CMP;
      ST_DAT_CMP: state_nxt = s_match ? ST_DAT_ACK : ST_DAT_RD;
      ST_DAT_NEW: if (can_load) state_nxt = ST_DAT_ACK;
      ST_DAT_ACK: if (can_load) state_nxt = ST_IDLE;
      ST_TK_RD:   state_nxt = pscan_end ? ST_TK_FLUSH : ST_TK_CMP;
      ST_TK_CMP: begin
        if (!due || !hold_v_r || can_load) state_nxt = ST_TK_RD;
      end
      ST_TK_FLUSH: if (!hold_v_r || can_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, table ports and result register.
  always_comb begin
    it_nxt     = it_r;
    pi_nxt     = pi_r;
    si_nxt     = si_r;
    k_nxt      = k_r;
    pcnt_nxt   = pcnt_r;
    scnt_nxt   = scnt_r;
    nseq_nxt   = nseq_r;
    now_nxt    = now_r;
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    ov_nxt     = ov_r && out_stall;
    oact_nxt   = oact_r;
    oseq_nxt   = oseq_r;
    ohnd_nxt   = ohnd_r;
    opeer_nxt  = opeer_r;
    olast_nxt  = olast_r;
    pop        = 1'b0;
    p_we       = 1'b0;
    p_re       = 1'b0;
    p_waddr    = pcnt_r[PIW-1:0];
    p_raddr    = pi_r[PIW-1:0];
    p_wdata    = {it_r.seq, it_r.handle, it_r.peer, now_r};
    s_we       = 1'b0;
    s_re       = 1'b0;
    s_waddr    = scnt_r[SIW-1:0];
    s_raddr    = si_r[SIW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          it_nxt     = head.item;
          pi_nxt     = '0;
          si_nxt     = '0;
          k_nxt      = '0;
          hold_v_nxt = 1'b0;
          if (head.item.cmd == CMD_TICK) begin
            now_nxt = now_r + 32'd1;
          end
        end
      end
      ST_SEND: begin
        if (can_load) begin
          ov_nxt    = 1'b1;
          oseq_nxt  = nseq_r;
          ohnd_nxt  = it_r.handle;
          opeer_nxt = it_r.peer;
          olast_nxt = 1'b1;
          if (pcnt_r >= PCW'(PENDING_DEPTH)) begin
            oact_nxt = ACT_FULL;
          end else begin
            oact_nxt = ACT_TRANSMIT;
            p_we     = 1'b1;
            p_wdata  = {nseq_r, it_r.handle, it_r.peer, now_r};
            pcnt_nxt = pcnt_r + PCW'(1);
            nseq_nxt = nseq_r + 16'd1;
          end
        end
      end
      ST_ACK_RD: begin
        p_re = (pi_r < pcnt_r);
      end
      ST_ACK_CMP: begin
        if (!p_match) begin
          pi_nxt = pi_r + PCW'(1);
        end
      end
      ST_SH_RD: begin
        if (sh_end) begin
          pcnt_nxt = pcnt_r - PCW'(1);
        end else begin
          p_re    = 1'b1;
          p_raddr = pj1[PIW-1:0];
        end
      end
      ST_SH_WR: begin
        p_we    = 1'b1;
        p_waddr = pi_r[PIW-1:0];
        p_wdata = p_rdata;
        pi_nxt  = pj1;
      end
      ST_DAT_RD: begin
        s_re = (si_r < scnt_r);
      end
      ST_DAT_CMP: begin
        if (!s_match) begin
          si_nxt = si_r + SCW'(1);
        end
      end
      ST_DAT_NEW: begin
        if (can_load) begin
          ov_nxt    = 1'b1;
          oseq_nxt  = it_r.seq;
          ohnd_nxt  = 8'd0;
          opeer_nxt = it_r.peer;
          olast_nxt = 1'b0;
          if (scnt_r < SCW'(SEEN_DEPTH)) begin
            oact_nxt = ACT_DELIVER;
            s_we     = 1'b1;
            scnt_nxt = scnt_r + SCW'(1);
          end else begin
            oact_nxt = ACT_FULL;
          end
        end
      end
      ST_DAT_ACK: begin
        if (can_load) begin
          ov_nxt    = 1'b1;
          oact_nxt  = ACT_ACK;
          oseq_nxt  = it_r.seq;
          ohnd_nxt  = 8'd0;
          opeer_nxt = it_r.peer;
          olast_nxt = 1'b1;
        end
      end
      ST_TK_RD: begin
        p_re = !pscan_end;
      end
      ST_TK_CMP: begin
        if (!due) begin
          pi_nxt = pi_r + PCW'(1);
        end else if (!hold_v_r || can_load) begin
          // The previous hit goes out now; it was not the last one.
          if (hold_v_r) begin
            ov_nxt    = 1'b1;
            oact_nxt  = ACT_RETRANSMIT;
            oseq_nxt  = hold_r.seq;
            ohnd_nxt  = hold_r.handle;
            opeer_nxt = hold_r.peer;
            olast_nxt = 1'b0;
          end
          p_we       = 1'b1;
          p_waddr    = pi_r[PIW-1:0];
          p_wdata    = {p_ent.seq, p_ent.handle, p_ent.peer, now_r};
          hold_v_nxt = 1'b1;
          hold_nxt   = p_ent;
          k_nxt      = k_r + KW'(1);
          pi_nxt     = pi_r + PCW'(1);
        end
      end
      ST_TK_FLUSH: begin
        if (hold_v_r && can_load) begin
          ov_nxt     = 1'b1;
          oact_nxt   = ACT_RETRANSMIT;
          oseq_nxt   = hold_r.seq;
          ohnd_nxt   = hold_r.handle;
          opeer_nxt  = hold_r.peer;
          olast_nxt  = 1'b1;
          hold_v_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pcnt_r   <= '0;
      scnt_r   <= '0;
      nseq_r   <= '0;
      now_r    <= '0;
      hold_v_r <= 1'b0;
      ov_r     <= 1'b0;
      k_r      <= '0;
      pi_r     <= '0;
      si_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      pcnt_r   <= pcnt_nxt;
      scnt_r   <= scnt_nxt;
      nseq_r   <= nseq_nxt;
      now_r    <= now_nxt;
      hold_v_r <= hold_v_nxt;
      ov_r     <= ov_nxt;
      k_r      <= k_nxt;
      pi_r     <= pi_nxt;
      si_r     <= si_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r    <= it_nxt;
    hold_r  <= hold_nxt;
    oact_r  <= oact_nxt;
    oseq_r  <= oseq_nxt;
    ohnd_r  <= ohnd_nxt;
    opeer_r <= opeer_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid  = ov_r;
  assign out_action = oact_r;
  assign out_seq    = oseq_r;
  assign out_handle = ohnd_r;
  assign out_peer   = opeer_r;
  assign out_last   = olast_r;
  assign pend_cnt   = pcnt_r;
  assign seen_cnt   = scnt_r;

endmodule

[hdl/reliable_message_ack_engine.sv]
// Each table is scanned one entry at a time through its single registered read port:
// a read state, then a compare state. A stalled result holds the sequencer until taken.
// Reset (synchronous, active low) clears counters, time, sequence and queue;
// the tables need no clearing pass since only entries below the counts are read.
module reliable_message_ack_engine #(
  parameter int PENDING_DEPTH = rmae_pkg::PENDING_DEPTH_DEF,
  parameter int SEEN_DEPTH    = rmae_pkg::SEEN_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_seq_num,
  input  logic [7:0]  in_msg_handle,
  input  logic [7:0]  in_peer_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic [15:0] out_seq,
  output logic [7:0]  out_handle,
  output logic [7:0]  out_peer,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import rmae_pkg::*;

  qhead_t      head;
  logic        pop;
  logic [15:0] timeout_r;
  logic [$clog2(PENDING_DEPTH+1)-1:0] pend_cnt;
  logic [$clog2(SEEN_DEPTH+1)-1:0]    seen_cnt;

  // The timeout register accepts a transfer in any cycle; the user must see that it is only
  // written while the engine is idle, as the block itself does not enforce this.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_r <= cfg_data;
    end
  end

  // The front end queues up to two classified items so input transfers can continue while
  // the back end scans a table or waits on a stalled result.
  rmae_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_command(in_command), .in_seq_num(in_seq_num),
    .in_msg_handle(in_msg_handle), .in_peer_id(in_peer_id),
    .in_stall(in_stall), .head(head), .pop(pop)
  );

  // The back end owns both tables, the sequence counter and the tick clock.
  rmae_back #(.PENDING_DEPTH(PENDING_DEPTH), .SEEN_DEPTH(SEEN_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .pop(pop), .timeout(timeout_r),
    .out_valid(out_valid), .out_stall(out_stall), .out_action(out_action),
    .out_seq(out_seq), .out_handle(out_handle), .out_peer(out_peer),
    .out_last(out_last), .pend_cnt(pend_cnt), .seen_cnt(seen_cnt)
  );

`ifndef NO_ASSERTIONS
  // The pending table never holds more entries than it has room for.
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_cnt <= ($clog2(PENDING_DEPTH+1))'(PENDING_DEPTH))
    else $error("pending count overflow");

  // Received sequence numbers are never forgotten.
  a_seen_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> seen_cnt >= $past(seen_cnt))
    else $error("seen count decreased");

  // An ack is always the final result of its data item.
  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_ACK) |-> out_last)
    else $error("ack not marked last");
`endif

endmodule

[sim/tb.sv]
// Self-checking testbench for reliable_message_ack_engine: directed tests and random traffic
// against an in-bench bookkeeping predictor. Depends on rmae_pkg and the engine RTL.
module tb;
  import rmae_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PEND_DEPTH = 16;
  localparam int SEEN_DEPTH = 64;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_command;
  logic [15:0] in_seq_num;
  logic [7:0]  in_msg_handle;
  logic [7:0]  in_peer_id;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_action;
  logic [15:0] out_seq;
  logic [7:0]  out_handle;
  logic [7:0]  out_peer;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  reliable_message_ack_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_seq_num(in_seq_num), .in_msg_handle(in_msg_handle), .in_peer_id(in_peer_id),
    .out_valid(out_valid), .out_stall(out_stall), .out_action(out_action),
    .out_seq(out_seq), .out_handle(out_handle), .out_peer(out_peer),
    .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // One expected action record, as the engine reports it.
  typedef struct packed {
    act_t        act;
    logic [15:0] seq;
    logic [7:0]  handle;
    logic [7:0]  peer;
    logic        last;
  } action_rec_t;

  // Predictor state: a private copy of everything the engine remembers.
  pend_t       unacked [PEND_DEPTH];
  int          unacked_cnt;
  logic [15:0] seen_seqs [SEEN_DEPTH];
  int          seen_cnt;
  logic [15:0] seq_counter;
  logic [31:0] tick_now;
  logic [15:0] rto;

  action_rec_t expected_actions[$];
  bit          failed;
  int          gap_left;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Pushes one expected action; the caller marks the final one afterwards.
  task automatic push_action(input act_t a, input logic [15:0] s, input logic [7:0] h,
                             input logic [7:0] p);
    action_rec_t r;
    r.act = a; r.seq = s; r.handle = h; r.peer = p; r.last = 1'b0;
    expected_actions.push_back(r);
  endtask

  // Applies one accepted command to the predictor and queues the actions it causes.
  task automatic predict_engine(input cmd_t c, input logic [15:0] s, input logic [7:0] h,
                                input logic [7:0] p);
    int n;
    int hit;
    logic [31:0] age;
    action_rec_t r;
    n = 0;
    case (c)
      CMD_SEND: begin
        if (unacked_cnt >= PEND_DEPTH) begin
          push_action(ACT_FULL, seq_counter, h, p);
        end else begin
          unacked[unacked_cnt] = '{seq: seq_counter, handle: h, peer: p, stamp: tick_now};
          unacked_cnt++;
          push_action(ACT_TRANSMIT, seq_counter, h, p);
          seq_counter = seq_counter + 16'd1;
        end
        n = 1;
      end
      CMD_ACK: begin
        for (int i = 0; i < unacked_cnt; i++) begin
          if (unacked[i].seq == s) begin
            for (int j = i; j + 1 < unacked_cnt; j++) unacked[j] = unacked[j + 1];
            unacked_cnt--;
            break;
          end
        end
      end
      CMD_DATA: begin
        hit = 0;
        for (int i = 0; i < seen_cnt; i++) if (seen_seqs[i] == s) hit = 1;
        if (!hit) begin
          if (seen_cnt < SEEN_DEPTH) begin
            seen_seqs[seen_cnt] = s;
            seen_cnt++;
            push_action(ACT_DELIVER, s, 8'd0, p);
          end else begin
            push_action(ACT_FULL, s, 8'd0, p);
          end
          n++;
        end
        push_action(ACT_ACK, s, 8'd0, p);
        n++;
      end
      default: begin
        tick_now = tick_now + 32'd1;
        for (int i = 0; i < unacked_cnt && n < MAX_RESULTS; i++) begin
          age = tick_now - unacked[i].stamp;
          if (age >= {16'd0, rto}) begin
            unacked[i].stamp = tick_now;
            push_action(ACT_RETRANSMIT, unacked[i].seq, unacked[i].handle, unacked[i].peer);
            n++;
          end
        end
      end
    endcase
    if (n > 0) begin
      r = expected_actions.pop_back();
      r.last = 1'b1;
      expected_actions.push_back(r);
    end
  endtask

  // Sends one command through the input channel, with burst gaps in front of it.
  task automatic send_command(input cmd_t c, input logic [15:0] s, input logic [7:0] h,
                              input logic [7:0] p);
    if (gap_left == 0) begin
      // Start a new burst: a random pause, then a run of back-to-back transfers.
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) @(negedge clk);
      gap_left = $urandom_range(1, 12);
    end
    gap_left--;
    in_valid      = 1'b1;
    in_command    = c;
    in_seq_num    = s;
    in_msg_handle = h;
    in_peer_id    = p;
    do @(posedge clk); while (in_stall);
    predict_engine(c, s, h, p);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Waits until every predicted action has arrived, then lets the engine settle.
  task automatic drain_engine();
    while (expected_actions.size() != 0) @(negedge clk);
    repeat (3 * PEND_DEPTH + 2 * SEEN_DEPTH + 10) @(negedge clk);
  endtask

  // Writes the timeout register while the engine is idle.
  task automatic write_timeout(input logic [15:0] v);
    drain_engine();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    rto = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver stall pattern: long open stretches, stall bursts of random length.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (out_stall) begin
      out_stall <= ($urandom_range(0, 3) != 0);
    end else begin
      out_stall <= ($urandom_range(0, 9) == 0);
    end
  end

  // Result checker: each transfer is compared with the oldest expected action.
  always @(posedge clk) begin
    action_rec_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_actions.size() == 0) begin
        $display("%0t: unexpected action %0d seq %0d handle %0d peer %0d last %0b",
                 $time, out_action, out_seq, out_handle, out_peer, out_last);
        failed = 1'b1;
      end else begin
        e = expected_actions.pop_front();
        if (out_action !== e.act)
          $display("%0t: action expected %0d actual %0d", $time, e.act, out_action);
        if (out_seq !== e.seq)
          $display("%0t: seq expected %0d actual %0d", $time, e.seq, out_seq);
        if (out_handle !== e.handle)
          $display("%0t: handle expected %0d actual %0d", $time, e.handle, out_handle);
        if (out_peer !== e.peer)
          $display("%0t: peer expected %0d actual %0d", $time, e.peer, out_peer);
        if (out_last !== e.last)
          $display("%0t: last expected %0b actual %0b", $time, e.last, out_last);
        if (out_action !== e.act || out_seq !== e.seq || out_handle !== e.handle ||
            out_peer !== e.peer || out_last !== e.last) failed = 1'b1;
      end
    end
  end

  // Send, full pending table, ack in the middle and at the ends, unmatched ack.
  task automatic test_pending_table();
    send_command(CMD_SEND, 16'hFFFF, 8'hFF, 8'h00);
    send_command(CMD_SEND, 16'h0000, 8'h00, 8'hFF);
    for (int i = 2; i < PEND_DEPTH; i++) send_command(CMD_SEND, 16'h0, 8'(i), 8'(i * 7));
    send_command(CMD_SEND, 16'h0, 8'hA5, 8'h5A);   // table full
    send_command(CMD_ACK, 16'd7, 8'h0, 8'h0);
    send_command(CMD_ACK, 16'd0, 8'h0, 8'h0);
    send_command(CMD_ACK, 16'd15, 8'h0, 8'h0);
    send_command(CMD_ACK, 16'hFFFF, 8'hFF, 8'hFF);  // no match
  endtask

  // Ticks: entries age out at the reset timeout and get restamped.
  task automatic test_retransmit();
    send_command(CMD_TICK, 16'hFFFF, 8'hFF, 8'hFF);
    send_command(CMD_TICK, 16'h0, 8'h0, 8'h0);
    send_command(CMD_TICK, 16'h0, 8'h0, 8'h0);
  endtask

  // New, duplicate and extreme data sequence numbers.
  task automatic test_data_path();
    send_command(CMD_DATA, 16'h0000, 8'hFF, 8'h00);
    send_command(CMD_DATA, 16'hFFFF, 8'h00, 8'hFF);
    send_command(CMD_DATA, 16'hFFFF, 8'h00, 8'h12);  // duplicate
  endtask

  // Fills the seen table, then offers fresh data that cannot be recorded.
  task automatic test_seen_full();
    for (int i = seen_cnt; i < SEEN_DEPTH + 2; i++)
      send_command(CMD_DATA, 16'(16'h1000 + i), 8'h0, 8'(i));
    send_command(CMD_DATA, 16'h1000 + 16'd5, 8'h0, 8'h33);   // duplicate while full
  endtask

  // Zero timeout: every pending entry goes out on each tick, up to the result limit.
  task automatic test_zero_timeout();
    write_timeout(16'd0);
    while (unacked_cnt < PEND_DEPTH) send_command(CMD_SEND, 16'h0, 8'($urandom), 8'($urandom));
    repeat (3) send_command(CMD_TICK, 16'h0, 8'h0, 8'h0);
  endtask

  // Random traffic: sends, acks mostly of live sequence numbers, data and ticks.
  task automatic test_random_traffic(input int count, input logic [15:0] timeout);
    logic [15:0] s;
    int k;
    write_timeout(timeout);
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 99);
      s = 16'($urandom);
      if (k < 30) begin
        send_command(CMD_SEND, s, 8'($urandom), 8'($urandom));
      end else if (k < 55) begin
        if (unacked_cnt > 0 && $urandom_range(0, 4) != 0)
          s = unacked[$urandom_range(0, unacked_cnt - 1)].seq;
        send_command(CMD_ACK, s, 8'($urandom), 8'($urandom));
      end else if (k < 70) begin
        if (seen_cnt > 0 && $urandom_range(0, 2) == 0)
          s = seen_seqs[$urandom_range(0, seen_cnt - 1)];
        send_command(CMD_DATA, s, 8'($urandom), 8'($urandom));
      end else begin
        send_command(CMD_TICK, s, 8'($urandom), 8'($urandom));
      end
      // Pressure: now and then hold off until the engine has emptied its output.
      if (n % 97 == 50) while (expected_actions.size() != 0) @(negedge clk);
    end
  endtask

  // Closing run of ack/send pairs; each ack frees room for the send after it.
  task automatic test_sequence_wrap();
    repeat (8) begin
      if (unacked_cnt > 0) send_command(CMD_ACK, unacked[0].seq, 8'h0, 8'h0);
      send_command(CMD_SEND, 16'h0, 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_SEND;
    in_seq_num = '0;
    in_msg_handle = '0;
    in_peer_id = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    failed = 1'b0;
    gap_left = 0;
    unacked_cnt = 0;
    seen_cnt = 0;
    seq_counter = '0;
    tick_now = '0;
    rto = TIMEOUT_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_pending_table();
    test_retransmit();
    test_data_path();
    test_random_traffic(120, 16'd1);
    test_seen_full();
    test_zero_timeout();
    test_random_traffic(120, 16'hFFFF);
    test_random_traffic(140, 16'd3);
    test_sequence_wrap();

    drain_engine();
    if (!failed && expected_actions.size() == 0) begin
      $display("reliable_message_ack_engine verification clean");
    end else begin
      $display("reliable_message_ack_engine verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20ms;
    $display("reliable_message_ack_engine verification failed");
    $finish;
  end

endmodule
